/* rtl/cascaded_biquad_equalizer_core_macros.svh */
// Assertion macros shared by the equalizer RTL.
// Depends on a clock named clk and a synchronous reset named rst in the including module.
`ifndef CASCADED_BIQUAD_EQUALIZER_CORE_MACROS_SVH
`define CASCADED_BIQUAD_EQUALIZER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CBEQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define CBEQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/cbeq_pkg.sv */
// Shared codes for the cascaded biquad equalizer: item kinds and coefficient slots.
// No dependencies.
`timescale 1ns / 1ps

package cbeq_pkg;

  typedef enum logic [1:0] {
    KIND_SAMPLE     = 2'd0,
    KIND_COEF_WRITE = 2'd1,
    KIND_BAND_WRITE = 2'd2,
    KIND_CLEAR_HIST = 2'd3
  } kind_t;

  // Coefficients per band, in slot order a0, a1, a2, b1, b2.
  localparam int NCOEF = 5;

  typedef enum logic [2:0] {
    TAP_A0 = 3'd0,
    TAP_A1 = 3'd1,
    TAP_A2 = 3'd2,
    TAP_B1 = 3'd3,
    TAP_B2 = 3'd4,
    TAP_END = 3'd5,
    TAP_ACC = 3'd6
  } tap_t;

  localparam int ACC_W = 64;

endpackage

/* rtl/cascaded_biquad_equalizer_core.sv */
// Cascaded biquad equalizer: NUM_BANDS direct-form-I sections on one shared multiplier.
// Flow: per band, S_BAND fetches history and skips a disabled band; an enabled band then runs
//   S_MAC (coefficient fetch, multiply/accumulate) and S_ROUND. Master off: straight to S_DONE.
// Items are accepted only in S_IDLE; control items one per cycle while no sample is in flight.
// Reset (rst, synchronous): eq_enable and band enables off, a0 = 1.0, history reads as zero.
// Depends on cbeq_pkg and cascaded_biquad_equalizer_core_macros.svh.
`timescale 1ns / 1ps
`include "cascaded_biquad_equalizer_core_macros.svh"

module cascaded_biquad_equalizer_core #(
  parameter int NUM_BANDS      = 10,
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 28,
  localparam int IN_W  = ((SAMPLE_BITS + 40 + 7) / 8) * 8,
  localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             eq_enable_we,
  input  logic             eq_enable_wdata,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // sample_in, band_index[3:0], coef_select[2:0], coef_value[31:0], band_on
  input  logic [IN_W-1:0]  s_axis_tdata,
  // kind[1:0]
  input  cbeq_pkg::kind_t  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // sample_out
  output logic [OUT_W-1:0] m_axis_tdata
);
  import cbeq_pkg::*;

  localparam int SB       = SAMPLE_BITS;
  localparam int NUM_COEF = NUM_BANDS * NCOEF;
  localparam int CA_W     = $clog2(NUM_COEF);
  localparam int BAND_W   = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam int PROD_W   = 32 + SB;
  localparam logic signed [31:0] COEF_ONE = 32'sd1 <<< COEF_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = 64'sd1 <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI = (64'sd1 <<< (SB - 1)) - 64'sd1;
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - 64'sd1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_BAND  = 5'b00010,
    S_MAC   = 5'b00100,
    S_ROUND = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  typedef struct packed {
    logic signed [SB-1:0] x1;
    logic signed [SB-1:0] x2;
    logic signed [SB-1:0] y1;
    logic signed [SB-1:0] y2;
  } hist_t;

  // Input fields
  logic signed [SB-1:0] sample_in;
  logic [3:0]           band_index;
  logic [2:0]           coef_select;
  logic signed [31:0]   coef_value;
  logic                 band_on;

  assign sample_in   = s_axis_tdata[SB-1:0];
  assign band_index  = s_axis_tdata[SB+3:SB];
  assign coef_select = s_axis_tdata[SB+6:SB+4];
  assign coef_value  = s_axis_tdata[SB+38:SB+7];
  assign band_on     = s_axis_tdata[SB+39];

  state_t                 state;
  logic                   eq_enable;
  logic [NUM_BANDS-1:0]   band_en;
  logic [BAND_W-1:0]      band;
  logic [CA_W-1:0]        coef_base;
  tap_t                   tap;
  logic signed [SB-1:0]   sample;
  logic signed [ACC_W-1:0] acc;
  logic signed [PROD_W-1:0] prod;
  logic                   prod_neg;

  // Coefficient memory with per-entry valid bits standing in for the reset value
  logic signed [31:0]     coef_mem [NUM_COEF];
  logic [NUM_COEF-1:0]    coef_valid;
  logic signed [31:0]     coef_q;
  logic [CA_W-1:0]        coef_rd_addr;
  logic [CA_W-1:0]        coef_wr_addr;
  logic                   coef_wr;
  logic                   coef_rd;

  // History memory, one row per band; rows not valid read as zero
  hist_t                  hist_mem [NUM_BANDS];
  logic [NUM_BANDS-1:0]   hist_valid;
  hist_t                  hist_q;
  hist_t                  hist_wr_data;
  logic                   hist_wr;

  logic                   in_fire;
  logic                   sample_fire;
  logic                   last_band;
  logic [2:0]             op_sel;
  logic signed [SB-1:0]   mul_op;
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [ACC_W-1:0] acc_shr;
  logic signed [SB-1:0]   y_new;

  assign s_axis_tready = (state == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign sample_fire   = in_fire && (s_axis_tuser == KIND_SAMPLE);
  assign last_band     = (band == BAND_W'(NUM_BANDS - 1));

  assign coef_wr = in_fire && (s_axis_tuser == KIND_COEF_WRITE) &&
                   (32'(band_index) < NUM_BANDS) && (coef_select < 3'(NCOEF));
  assign coef_wr_addr = CA_W'(32'(band_index) * NCOEF + 32'(coef_select));
  assign coef_rd      = (state == S_MAC) && (tap < TAP_END);
  assign coef_rd_addr = coef_base + CA_W'(tap);

  // Multiplier operand follows the coefficient fetched in the previous cycle
  assign op_sel = tap - 3'd1;
  always_comb begin
    unique case (op_sel)
      TAP_A0:  mul_op = sample;
      TAP_A1:  mul_op = hist_q.x1;
      TAP_A2:  mul_op = hist_q.x2;
      TAP_B1:  mul_op = hist_q.y1;
      default: mul_op = hist_q.y2;
    endcase
  end

  // Round half up, floor, then clamp to the sample range
  assign acc_rnd = acc + ROUND_HALF;
  assign acc_shr = acc_rnd >>> COEF_FRAC_BITS;
  always_comb begin
    priority if (acc_shr > SAT_HI) begin
      y_new = SB'(SAT_HI);
    end else if (acc_shr < SAT_LO) begin
      y_new = SB'(SAT_LO);
    end else begin
      y_new = SB'(acc_shr);
    end
  end

  assign hist_wr = (state == S_ROUND);
  always_comb begin
    hist_wr_data.x1 = sample;
    hist_wr_data.x2 = hist_q.x1;
    hist_wr_data.y1 = y_new;
    hist_wr_data.y2 = hist_q.y1;
  end

  // Memories
  always_ff @(posedge clk) begin
    if (coef_wr) begin
      coef_mem[coef_wr_addr] <= coef_value;
    end
    if (coef_rd) begin
      if (coef_valid[coef_rd_addr]) begin
        coef_q <= coef_mem[coef_rd_addr];
      end else begin
        coef_q <= (tap == TAP_A0) ? COEF_ONE : 32'sd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hist_wr) begin
      hist_mem[band] <= hist_wr_data;
    end
    if (state == S_BAND) begin
      hist_q <= hist_valid[band] ? hist_mem[band] : '0;
    end
  end

  // Valid bits, enables and master enable
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_valid <= '0;
      hist_valid <= '0;
      band_en    <= '0;
      eq_enable  <= 1'b0;
    end else begin
      if (eq_enable_we) begin
        eq_enable <= eq_enable_wdata;
      end
      if (coef_wr) begin
        coef_valid[coef_wr_addr] <= 1'b1;
      end
      if (in_fire && (s_axis_tuser == KIND_BAND_WRITE)) begin
        for (int i = 0; i < NUM_BANDS; i++) begin
          if (32'(band_index) == i) begin
            band_en[i] <= band_on;
          end
        end
      end
      if (in_fire && (s_axis_tuser == KIND_CLEAR_HIST)) begin
        hist_valid <= '0;
      end else if (hist_wr) begin
        hist_valid[band] <= 1'b1;
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      band          <= '0;
      coef_base     <= '0;
      tap           <= TAP_A0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // the done state reloads the output register itself
      if (m_axis_tvalid && m_axis_tready && (state != S_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire && (s_axis_tuser == KIND_SAMPLE)) begin
            band      <= '0;
            coef_base <= '0;
            state     <= eq_enable ? S_BAND : S_DONE;
          end
        end
        S_BAND: begin
          tap <= TAP_A0;
          if (band_en[band]) begin
            state <= S_MAC;
          end else if (last_band) begin
            state <= S_DONE;
          end else begin
            band      <= band + BAND_W'(1);
            coef_base <= coef_base + CA_W'(NCOEF);
          end
        end
        S_MAC: begin
          if (tap == TAP_ACC) begin
            state <= S_ROUND;
          end else begin
            tap <= tap_t'(tap + 3'd1);
          end
        end
        S_ROUND: begin
          if (last_band) begin
            state <= S_DONE;
          end else begin
            band      <= band + BAND_W'(1);
            coef_base <= coef_base + CA_W'(NCOEF);
            state     <= S_BAND;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath: sample register, shared multiplier and accumulator
  always_ff @(posedge clk) begin
    if (in_fire && (s_axis_tuser == KIND_SAMPLE)) begin
      sample <= sample_in;
    end else if (state == S_ROUND) begin
      sample <= y_new;
    end
    if (state == S_BAND) begin
      acc <= '0;
    end else if (state == S_MAC) begin
      if (tap != TAP_A0 && tap != TAP_ACC) begin
        prod     <= coef_q * mul_op;
        prod_neg <= (op_sel == TAP_B1) || (op_sel == TAP_B2);
      end
      if (tap != TAP_A0 && tap != TAP_A1) begin
        acc <= prod_neg ? acc - ACC_W'(prod) : acc + ACC_W'(prod);
      end
    end
    if ((state == S_DONE) && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= OUT_W'(unsigned'(sample));
    end
  end

  `CBEQ_ASSERT_NEXT(a_bypass_direct, sample_fire && !eq_enable, state == S_DONE, "no bypass")
  `CBEQ_ASSERT_NEXT(a_ctrl_single, in_fire && !sample_fire, state == S_IDLE, "control busy")
  `CBEQ_ASSERT_NEXT(a_mac_to_round, state == S_MAC && tap == TAP_ACC, state == S_ROUND, "no round")
  `CBEQ_ASSERT_NOW(a_out_from_done, $rose(m_axis_tvalid), $past(state == S_DONE), "stray valid")

endmodule
